### sv/trvg_pkg.sv
// ----------------------------------------------------------------------------
// trvg_pkg
// Shared types, constants and tables of the tube ring vertex generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package trvg_pkg;

    // Largest legal segment count.
    localparam int MAX_SEGMENTS = 64;

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_SEGMENTS     = 3'd0;
    localparam logic [2:0] REG_START_AXIAL  = 3'd1;
    localparam logic [2:0] REG_START_RADIUS = 3'd2;
    localparam logic [2:0] REG_END_AXIAL    = 3'd3;
    localparam logic [2:0] REG_END_RADIUS   = 3'd4;
    localparam logic [2:0] REG_CENTRE_2ND   = 3'd5;
    localparam logic [2:0] REG_CENTRE_3RD   = 3'd6;
    localparam logic [2:0] REG_AXIS         = 3'd7;

    // Axis permutation codes; every other code acts as the first axis.
    localparam logic [1:0] AXIS_SECOND = 2'd2;
    localparam logic [1:0] AXIS_THIRD  = 2'd3;

    // Chain lengths.
    localparam int PHASE_STEPS  = 25;
    localparam int RATIO_STEPS  = 14;
    localparam int SQRT_STEPS   = 29;
    localparam int CORDIC_STEPS = 19;

    // Gain-compensated CORDIC start value, Q2.28.
    localparam logic signed [31:0] CORDIC_START = 32'sd163008219;

    // One restoring division step: remainder, shifting dividend/quotient, divisor.
    typedef struct packed {
        logic [29:0] rem;
        logic [24:0] acc;
        logic [29:0] dvs;
    } div_t;

    // One square root digit step.
    typedef struct packed {
        logic [29:0] rem;
        logic [28:0] root;
        logic [57:0] rad;
    } sqrt_t;

    // One CORDIC rotation step, with the quadrant carried alongside.
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [24:0] z;
        logic [1:0]         quad;
    } cordic_t;

    // Arctangent of 2^-i in units of 2^-24 turn.
    function automatic logic signed [24:0] cordic_atan(input logic [4:0] step);
        logic signed [24:0] a;
        case (step)
            5'd0:    a = 25'sd2097152;
            5'd1:    a = 25'sd1238021;
            5'd2:    a = 25'sd654136;
            5'd3:    a = 25'sd332050;
            5'd4:    a = 25'sd166669;
            5'd5:    a = 25'sd83416;
            5'd6:    a = 25'sd41718;
            5'd7:    a = 25'sd20860;
            5'd8:    a = 25'sd10430;
            5'd9:    a = 25'sd5215;
            5'd10:   a = 25'sd2608;
            5'd11:   a = 25'sd1304;
            5'd12:   a = 25'sd652;
            5'd13:   a = 25'sd326;
            5'd14:   a = 25'sd163;
            5'd15:   a = 25'sd81;
            5'd16:   a = 25'sd41;
            5'd17:   a = 25'sd20;
            5'd18:   a = 25'sd10;
            default: a = 25'sd0;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

### sv/trvg_div_cell.sv
// ----------------------------------------------------------------------------
// trvg_div_cell
// One restoring division step: produces one quotient bit per cycle while en is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module trvg_div_cell (
    input  wire logic          clk,
    input  wire logic          en,
    input  wire trvg_pkg::div_t d_in,
    output trvg_pkg::div_t     d_out
);
    import trvg_pkg::*;

    logic [30:0] shifted;
    logic        ge;
    logic [30:0] diff;
    div_t        step_next;
    div_t        step_reg;

    // Bring in the next dividend bit and try to subtract the divisor.
    always_comb
    begin
        shifted   = {d_in.rem, d_in.acc[24]};
        ge        = shifted >= {1'b0, d_in.dvs};
        diff      = shifted - {1'b0, d_in.dvs};
        step_next.rem = ge ? diff[29:0] : shifted[29:0];
        step_next.acc = {d_in.acc[23:0], ge};
        step_next.dvs = d_in.dvs;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            step_reg <= step_next;
        end
    end

    assign d_out = step_reg;

endmodule

`default_nettype wire

### sv/trvg_sqrt_cell.sv
// ----------------------------------------------------------------------------
// trvg_sqrt_cell
// One digit step of a restoring integer square root.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module trvg_sqrt_cell (
    input  wire logic           clk,
    input  wire logic           en,
    input  wire trvg_pkg::sqrt_t d_in,
    output trvg_pkg::sqrt_t     d_out
);
    import trvg_pkg::*;

    logic [31:0] trial_a;
    logic [31:0] trial_b;
    logic [31:0] diff;
    logic        ge;
    sqrt_t       step_next;
    sqrt_t       step_reg;

    // Append two radicand bits and test the next root bit.
    always_comb
    begin
        trial_a = {d_in.rem, d_in.rad[57:56]};
        trial_b = {1'b0, d_in.root, 2'b01};
        ge      = trial_a >= trial_b;
        diff    = trial_a - trial_b;
        step_next.rem  = ge ? diff[29:0] : trial_a[29:0];
        step_next.root = {d_in.root[27:0], ge};
        step_next.rad  = {d_in.rad[55:0], 2'b00};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            step_reg <= step_next;
        end
    end

    assign d_out = step_reg;

endmodule

`default_nettype wire

### sv/trvg_cordic_cell.sv
// ----------------------------------------------------------------------------
// trvg_cordic_cell
// One rotation step of the sine/cosine CORDIC.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module trvg_cordic_cell (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [4:0]       step,
    input  wire trvg_pkg::cordic_t d_in,
    output trvg_pkg::cordic_t     d_out
);
    import trvg_pkg::*;

    logic signed [31:0] x_sh;
    logic signed [31:0] y_sh;
    logic signed [24:0] ang;
    cordic_t            rot_next;
    cordic_t            rot_reg;

    // Rotate toward zero residual angle.
    always_comb
    begin
        x_sh = d_in.x >>> step;
        y_sh = d_in.y >>> step;
        ang  = cordic_atan(step);
        if (!d_in.z[24])
        begin
            rot_next.x = d_in.x - y_sh;
            rot_next.y = d_in.y + x_sh;
            rot_next.z = d_in.z - ang;
        end
        else
        begin
            rot_next.x = d_in.x + y_sh;
            rot_next.y = d_in.y - x_sh;
            rot_next.z = d_in.z + ang;
        end
        rot_next.quad = d_in.quad;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rot_reg <= rot_next;
        end
    end

    assign d_out = rot_reg;

endmodule

`default_nettype wire

### sv/tube_ring_vertex_generator.sv
// ----------------------------------------------------------------------------
// Throughput: one item per cycle; the whole pipeline stalls only while a
// result waits at the output. The depth is set by the phase divider and
// CORDIC chains and by the square root and ratio divider chains.
// Reset clears the pipeline valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
// tube_ring_vertex_generator
// Computes start and end ring vertices and the surface normal of a frustum
// for one segment index per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tube_ring_vertex_generator (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [6:0]  segment_index,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic signed [15:0] ring_start_c0,
    output logic signed [15:0] ring_start_c1,
    output logic signed [15:0] ring_start_c2,
    output logic signed [15:0] ring_end_c0,
    output logic signed [15:0] ring_end_c1,
    output logic signed [15:0] ring_end_c2,
    output logic signed [15:0] normal_c0,
    output logic signed [15:0] normal_c1,
    output logic signed [15:0] normal_c2,
    output logic             invalid
);
    import trvg_pkg::*;

    localparam int LAST = 49;

    // Configuration registers.
    logic [6:0]         segments_reg;
    logic signed [15:0] start_axial_reg;
    logic signed [15:0] start_radius_reg;
    logic signed [15:0] end_axial_reg;
    logic signed [15:0] end_radius_reg;
    logic signed [15:0] centre_2nd_reg;
    logic signed [15:0] centre_3rd_reg;
    logic [1:0]         axis_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            segments_reg     <= 7'd16;
            start_axial_reg  <= 16'sd0;
            start_radius_reg <= 16'sd0;
            end_axial_reg    <= 16'sd4096;
            end_radius_reg   <= 16'sd0;
            centre_2nd_reg   <= 16'sd0;
            centre_3rd_reg   <= 16'sd0;
            axis_reg         <= 2'd1;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_SEGMENTS:     segments_reg     <= cfg_data[6:0];
                REG_START_AXIAL:  start_axial_reg  <= cfg_data;
                REG_START_RADIUS: start_radius_reg <= cfg_data;
                REG_END_AXIAL:    end_axial_reg    <= cfg_data;
                REG_END_RADIUS:   end_radius_reg   <= cfg_data;
                REG_CENTRE_2ND:   centre_2nd_reg   <= cfg_data;
                REG_CENTRE_3RD:   centre_3rd_reg   <= cfg_data;
                REG_AXIS:         axis_reg         <= cfg_data[1:0];
                default:          ;
            endcase
        end
    end

    // Shape differences; the user must change registers only while no item is in flight (not enforced).
    logic signed [16:0] dx;
    logic signed [16:0] dr;
    logic [15:0]        dx_mag;
    logic [15:0]        dr_mag;

    assign dx     = 17'(end_axial_reg) - 17'(start_axial_reg);
    assign dr     = 17'(end_radius_reg) - 17'(start_radius_reg);
    assign dx_mag = dx[16] ? 16'(-dx) : dx[15:0];
    assign dr_mag = dr[16] ? 16'(-dr) : dr[15:0];

    // Pipeline control: everything advances unless a result is held.
    logic             adv;
    logic [LAST:0]    valid_reg;
    logic [LAST-1:0]  inv_reg;
    logic             inv_next;

    assign adv      = !valid_reg[LAST] || out_ready;
    assign in_ready = adv;

    assign inv_next = (segments_reg < 7'd3)
                   || (segments_reg > 7'(MAX_SEGMENTS))
                   || (dx == 17'sd0 && dr == 17'sd0)
                   || (segment_index > segments_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[LAST-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            inv_reg <= {inv_reg[LAST-2:0], inv_next};
        end
    end

    // Front stage: segment index.
    logic [6:0] j_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            j_reg <= segment_index;
        end
    end

    // Phase divider chain: round(j * 2^24 / n).
    div_t phase_init;
    div_t phase_chain [PHASE_STEPS];

    always_comb
    begin
        phase_init.rem = {24'd0, j_reg[6:1]};
        phase_init.acc = {j_reg[0], 18'd0, segments_reg[6:1]};
        phase_init.dvs = {23'd0, segments_reg};
    end

    for (genvar i = 0; i < PHASE_STEPS; i++)
    begin : g_phase
        trvg_div_cell u_cell (
            .clk   (clk),
            .en    (adv),
            .d_in  ((i == 0) ? phase_init : phase_chain[(i == 0) ? 0 : i - 1]),
            .d_out (phase_chain[i])
        );
    end

    // CORDIC chain on the low 22 phase bits.
    cordic_t cordic_init;
    cordic_t cordic_chain [CORDIC_STEPS];

    always_comb
    begin
        cordic_init.x    = CORDIC_START;
        cordic_init.y    = 32'sd0;
        cordic_init.z    = {3'd0, phase_chain[PHASE_STEPS-1].acc[21:0]};
        cordic_init.quad = phase_chain[PHASE_STEPS-1].acc[23:22];
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cordic
        trvg_cordic_cell u_cell (
            .clk   (clk),
            .en    (adv),
            .step  (5'(i)),
            .d_in  ((i == 0) ? cordic_init : cordic_chain[(i == 0) ? 0 : i - 1]),
            .d_out (cordic_chain[i])
        );
    end

    // Quadrant folding, then delay to meet the ratio path.
    logic signed [31:0] sn_next;
    logic signed [31:0] cs_next;
    logic signed [31:0] sn45_reg;
    logic signed [31:0] cs45_reg;
    logic signed [31:0] sn46_reg;
    logic signed [31:0] cs46_reg;
    logic signed [31:0] sn47_reg;
    logic signed [31:0] cs47_reg;

    always_comb
    begin
        case (cordic_chain[CORDIC_STEPS-1].quad)
            2'd0:
            begin
                cs_next = cordic_chain[CORDIC_STEPS-1].x;
                sn_next = cordic_chain[CORDIC_STEPS-1].y;
            end
            2'd1:
            begin
                cs_next = -cordic_chain[CORDIC_STEPS-1].y;
                sn_next = cordic_chain[CORDIC_STEPS-1].x;
            end
            2'd2:
            begin
                cs_next = -cordic_chain[CORDIC_STEPS-1].x;
                sn_next = -cordic_chain[CORDIC_STEPS-1].y;
            end
            default:
            begin
                cs_next = cordic_chain[CORDIC_STEPS-1].y;
                sn_next = -cordic_chain[CORDIC_STEPS-1].x;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sn45_reg <= sn_next;
            cs45_reg <= cs_next;
            sn46_reg <= sn45_reg;
            cs46_reg <= cs45_reg;
            sn47_reg <= sn46_reg;
            cs47_reg <= cs46_reg;
        end
    end

    // Squares of the shape differences and their sum.
    logic [32:0] sq_a_reg;
    logic [32:0] sq_b_reg;
    logic [33:0] sum_reg;
    logic signed [33:0] sq_a_full;
    logic signed [33:0] sq_b_full;

    assign sq_a_full = 34'(dx) * 34'(dx);
    assign sq_b_full = 34'(dr) * 34'(dr);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_a_reg <= sq_a_full[32:0];
            sq_b_reg <= sq_b_full[32:0];
            sum_reg  <= 34'(sq_a_reg) + 34'(sq_b_reg);
        end
    end

    // Square root chain: q = floor(sqrt(sum * 2^24)).
    sqrt_t sqrt_init;
    sqrt_t sqrt_chain [SQRT_STEPS];

    always_comb
    begin
        sqrt_init.rem  = '0;
        sqrt_init.root = '0;
        sqrt_init.rad  = {sum_reg, 24'd0};
    end

    for (genvar i = 0; i < SQRT_STEPS; i++)
    begin : g_sqrt
        trvg_sqrt_cell u_cell (
            .clk   (clk),
            .en    (adv),
            .d_in  ((i == 0) ? sqrt_init : sqrt_chain[(i == 0) ? 0 : i - 1]),
            .d_out (sqrt_chain[i])
        );
    end

    // Rounded dividends (magnitude * 2^24 + q/2) for both ratios.
    logic [28:0] q_root;
    logic [40:0] num_dx;
    logic [40:0] num_dr;
    div_t        rat_dx_init_reg;
    div_t        rat_dr_init_reg;

    assign q_root = sqrt_chain[SQRT_STEPS-1].root;
    assign num_dx = {1'b0, dx_mag, 24'd0} + 41'(q_root[28:1]);
    assign num_dr = {1'b0, dr_mag, 24'd0} + 41'(q_root[28:1]);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rat_dx_init_reg.rem <= {3'd0, num_dx[40:14]};
            rat_dx_init_reg.acc <= {num_dx[13:0], 11'd0};
            rat_dx_init_reg.dvs <= {1'b0, q_root};
            rat_dr_init_reg.rem <= {3'd0, num_dr[40:14]};
            rat_dr_init_reg.acc <= {num_dr[13:0], 11'd0};
            rat_dr_init_reg.dvs <= {1'b0, q_root};
        end
    end

    // Ratio divider chains.
    div_t rat_dx_chain [RATIO_STEPS];
    div_t rat_dr_chain [RATIO_STEPS];

    for (genvar i = 0; i < RATIO_STEPS; i++)
    begin : g_ratio
        trvg_div_cell u_cell_dx (
            .clk   (clk),
            .en    (adv),
            .d_in  ((i == 0) ? rat_dx_init_reg : rat_dx_chain[(i == 0) ? 0 : i - 1]),
            .d_out (rat_dx_chain[i])
        );
        trvg_div_cell u_cell_dr (
            .clk   (clk),
            .en    (adv),
            .d_in  ((i == 0) ? rat_dr_init_reg : rat_dr_chain[(i == 0) ? 0 : i - 1]),
            .d_out (rat_dr_chain[i])
        );
    end

    // Apply signs: radial = dx/h, axial normal = -dr/h.
    logic signed [14:0] quo_dx;
    logic signed [14:0] quo_dr;
    logic signed [14:0] radial_reg;
    logic signed [14:0] nax47_reg;
    logic signed [14:0] nax48_reg;

    assign quo_dx = {1'b0, rat_dx_chain[RATIO_STEPS-1].acc[13:0]};
    assign quo_dr = {1'b0, rat_dr_chain[RATIO_STEPS-1].acc[13:0]};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            radial_reg <= dx[16] ? -quo_dx : quo_dx;
            nax47_reg  <= dr[16] ? quo_dr : -quo_dr;
            nax48_reg  <= nax47_reg;
        end
    end

    // Products, Q.40.
    logic signed [47:0] p_s_sn_reg;
    logic signed [47:0] p_s_cs_reg;
    logic signed [47:0] p_e_sn_reg;
    logic signed [47:0] p_e_cs_reg;
    logic signed [47:0] p_n_sn_reg;
    logic signed [47:0] p_n_cs_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_s_sn_reg <= 48'(start_radius_reg) * 48'(sn47_reg);
            p_s_cs_reg <= 48'(start_radius_reg) * 48'(cs47_reg);
            p_e_sn_reg <= 48'(end_radius_reg) * 48'(sn47_reg);
            p_e_cs_reg <= 48'(end_radius_reg) * 48'(cs47_reg);
            p_n_sn_reg <= 48'(radial_reg) * 48'(sn47_reg);
            p_n_cs_reg <= 48'(radial_reg) * 48'(cs47_reg);
        end
    end

    // Round Q.40 to Q3.12, add an offset and saturate.
    function automatic logic signed [15:0] reduce_add(
        input logic signed [47:0] p,
        input logic signed [15:0] c
    );
        logic signed [47:0] t;
        logic signed [19:0] s;
        t = (p + 48'sd134217728) >>> 28;
        s = 20'(t) + 20'(c);
        if (s > 20'sd32767)
        begin
            return 16'sd32767;
        end
        else if (s < -20'sd32768)
        begin
            return -16'sd32768;
        end
        return s[15:0];
    endfunction

    // Output stage: permutation and invalid zeroing.
    logic signed [15:0] va_s;
    logic signed [15:0] vs_s;
    logic signed [15:0] vt_s;
    logic signed [15:0] va_e;
    logic signed [15:0] vs_e;
    logic signed [15:0] vt_e;
    logic signed [15:0] na;
    logic signed [15:0] ns;
    logic signed [15:0] nt;
    logic signed [15:0] out_next [9];
    logic signed [15:0] out_reg  [9];
    logic               inv_out_reg;

    always_comb
    begin
        va_s = start_axial_reg;
        vs_s = reduce_add(p_s_sn_reg, centre_2nd_reg);
        vt_s = reduce_add(p_s_cs_reg, centre_3rd_reg);
        va_e = end_axial_reg;
        vs_e = reduce_add(p_e_sn_reg, centre_2nd_reg);
        vt_e = reduce_add(p_e_cs_reg, centre_3rd_reg);
        na   = 16'(nax48_reg);
        ns   = reduce_add(p_n_sn_reg, 16'sd0);
        nt   = reduce_add(p_n_cs_reg, 16'sd0);
        case (axis_reg)
            AXIS_SECOND:
            begin
                out_next[0] = vt_s; out_next[1] = va_s; out_next[2] = vs_s;
                out_next[3] = vt_e; out_next[4] = va_e; out_next[5] = vs_e;
                out_next[6] = nt;   out_next[7] = na;   out_next[8] = ns;
            end
            AXIS_THIRD:
            begin
                out_next[0] = vs_s; out_next[1] = vt_s; out_next[2] = va_s;
                out_next[3] = vs_e; out_next[4] = vt_e; out_next[5] = va_e;
                out_next[6] = ns;   out_next[7] = nt;   out_next[8] = na;
            end
            default:
            begin
                out_next[0] = va_s; out_next[1] = vs_s; out_next[2] = vt_s;
                out_next[3] = va_e; out_next[4] = vs_e; out_next[5] = vt_e;
                out_next[6] = na;   out_next[7] = ns;   out_next[8] = nt;
            end
        endcase
        if (inv_reg[LAST-1])
        begin
            for (int k = 0; k < 9; k++)
            begin
                out_next[k] = 16'sd0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg     <= out_next;
            inv_out_reg <= inv_reg[LAST-1];
        end
    end

    assign out_valid     = valid_reg[LAST];
    assign ring_start_c0 = out_reg[0];
    assign ring_start_c1 = out_reg[1];
    assign ring_start_c2 = out_reg[2];
    assign ring_end_c0   = out_reg[3];
    assign ring_end_c1   = out_reg[4];
    assign ring_end_c2   = out_reg[5];
    assign normal_c0     = out_reg[6];
    assign normal_c1     = out_reg[7];
    assign normal_c2     = out_reg[8];
    assign invalid       = inv_out_reg;

endmodule

`default_nettype wire
